// File: rtl/cple_pkg.sv
// Package for the compact peer list extractor.
// Holds the parse phase type, keyword table, entry constants and the
// control struct between the top level and the keyword search unit.
package cple_pkg;

    // Keyword "peers" and entry layout
    localparam int unsigned KEY_LEN     = 5;
    localparam int unsigned ENTRY_BYTES = 6;
    localparam int unsigned KW_IDX_W    = 3;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned SHIFT_W     = 8 * (ENTRY_BYTES - 1);
    localparam int unsigned INDEX_W     = 16;

    localparam logic [7:0]         CHAR_COLON = 8'h3A;
    localparam logic [INDEX_W-1:0] INDEX_MAX  = '1;

    // Parse phase; the unused code falls into the default arm (searching)
    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_SKIP   = 2'd1,
        PH_DATA   = 2'd2
    } phase_t;

    // Control from the top level to the keyword search unit
    typedef struct packed {
        logic step;     // one byte taken while searching
        logic restart;  // end of response: clear progress
    } kw_ctrl_t;

    // Letter of "peers" at a given position
    function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h70; // p
            3'd1:    c = 8'h65; // e
            3'd2:    c = 8'h65; // e
            3'd3:    c = 8'h72; // r
            3'd4:    c = 8'h73; // s
            default: c = 8'h70;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/cple_keyword_search.sv
// Keyword search unit of the compact peer list extractor.
// Tracks how many letters of "peers" are matched; depends on cple_pkg.
module cple_keyword_search
    import cple_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  kw_ctrl_t   ctrl,
    input  logic [7:0] data_byte,
    output logic       hit
);

    logic [KW_IDX_W-1:0] progress_reg;
    logic [KW_IDX_W-1:0] progress_next;
    logic [KW_IDX_W-1:0] progress_step;

    // Advance on a match, restart at one on a fresh 'p', else drop to zero
    always_comb begin
        if (data_byte == kw_char(progress_reg)) begin
            progress_step = progress_reg + KW_IDX_W'(1);
        end else if (data_byte == kw_char('0)) begin
            progress_step = KW_IDX_W'(1);
        end else begin
            progress_step = '0;
        end
        hit = (progress_step == KW_IDX_W'(KEY_LEN));
    end

    // Clear at end of response; else hold progress unless a search byte arrives, clearing on a full match
    always_comb begin
        progress_next = progress_reg;
        if (ctrl.restart) begin
            progress_next = '0;
        end else if (ctrl.step) begin
            progress_next = hit ? '0 : progress_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            progress_reg <= '0;
        end else begin
            progress_reg <= progress_next;
        end
    end

endmodule

// File: rtl/compact_peer_list_extractor.sv
// Compact peer list extractor takes one byte of a tracker response per beat,
// finds the text "peers", skips through the next colon, and then emits one
// beat per complete 6-byte entry: the address (first byte on top), the
// big-endian port and the entry ordinal, saturating at 65535. A beat with
// tlast ends the response; a trailing partial entry is dropped and the
// parser returns to searching. A byte can be accepted every cycle; the only
// stall comes from the single output register, when a result is held and
// m_tready is low.
// Depends on cple_pkg and cple_keyword_search.
module compact_peer_list_extractor
    import cple_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_response
    // peer entries
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // [31:0] peer_address, [47:32] peer_port,
                                   // [63:48] peer_index
);

    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(ENTRY_BYTES - 1);

    phase_t              phase_reg,   phase_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [SHIFT_W-1:0]  shift_reg,   shift_next;
    logic [INDEX_W-1:0]  found_reg,   found_next;
    logic                m_valid_reg, m_valid_next;
    logic [63:0]         m_data_reg,  m_data_next;

    logic     s_accept;
    logic     emit;
    logic     kw_hit;
    kw_ctrl_t kw_ctrl;

    // Take a new byte whenever the output register is free or draining
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign kw_ctrl.step    = s_accept && (phase_reg != PH_SKIP) && (phase_reg != PH_DATA);
    assign kw_ctrl.restart = s_accept && s_tlast;

    cple_keyword_search u_kw (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (kw_ctrl),
        .data_byte (s_tdata),
        .hit       (kw_hit)
    );

    // Parse one byte: search, skip to colon, collect entry bytes
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        shift_next  = shift_reg;
        found_next  = found_reg;
        emit        = 1'b0;
        m_data_next = m_data_reg;
        if (s_accept) begin
            case (phase_reg)
                PH_SKIP: begin
                    if (s_tdata == CHAR_COLON) begin
                        phase_next = PH_DATA;
                        count_next = '0;
                        shift_next = '0;
                    end
                end
                PH_DATA: begin
                    if (count_reg < LAST_SLOT) begin
                        shift_next = {shift_reg[SHIFT_W-9:0], s_tdata};
                        count_next = count_reg + CNT_W'(1);
                    end else begin
                        emit        = 1'b1;
                        m_data_next = {found_reg, shift_reg[7:0], s_tdata,
                                       shift_reg[SHIFT_W-1:8]};
                        if (found_reg != INDEX_MAX) begin
                            found_next = found_reg + INDEX_W'(1);
                        end
                        count_next = '0;
                        shift_next = '0;
                    end
                end
                default: begin
                    phase_next = kw_hit ? PH_SKIP : PH_SEARCH;
                end
            endcase
            // End of response: back to searching, drop any partial entry
            if (s_tlast) begin
                phase_next = PH_SEARCH;
                count_next = '0;
                shift_next = '0;
                found_next = '0;
            end
        end
    end

    // Hold a result until taken, load a new one when an entry completes
    assign m_valid_next = emit || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SEARCH;
            count_reg   <= '0;
            shift_reg   <= '0;
            found_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            shift_reg   <= shift_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Entry byte count never passes the last slot
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= LAST_SLOT)
        else $error("entry byte count out of range");

    // A last byte returns the parser to searching with a cleared count
    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |=> phase_reg == PH_SEARCH && found_reg == '0
                                && count_reg == '0)
        else $error("state not cleared after end of response");

    // A new result only follows a byte accepted in the data phase
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !($past(m_tvalid) && !$past(m_tready))
            |-> $past(s_accept) && $past(phase_reg) == PH_DATA)
        else $error("result without a completed entry");

endmodule
